// ===== sv/tsde_pkg.sv =====
`default_nettype none
package tsde_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MUL_CHUNK = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int ENERGY_W = 64;
  localparam int QUOT_MIN_W = ENERGY_W + 2;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ENERGY_W-1:0] ENERGY_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic inv;
    logic neg;
  } tsde_flags_t;

  // pipeline stages of tsde_mul: magnitude stage, one stage per partial product, sign stage
  function automatic int mul_lat(input int wa, input int wb);
    return ((wa + MUL_CHUNK - 1) / MUL_CHUNK) * ((wb + MUL_CHUNK - 1) / MUL_CHUNK) + 2;
  endfunction

  // quotient bits kept; anything larger is certain to saturate
  function automatic int quot_w(input int dw);
    return (2 * dw + 1 > QUOT_MIN_W) ? 2 * dw + 1 : QUOT_MIN_W;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tsde_if.sv =====
`default_nettype none
interface tsde_in_if #(parameter int W = tsde_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [W-1:0] def_ax;
  logic signed [W-1:0] def_ay;
  logic signed [W-1:0] def_bx;
  logic signed [W-1:0] def_by;
  logic signed [W-1:0] def_cx;
  logic signed [W-1:0] def_cy;
  logic signed [W-1:0] ref_ax;
  logic signed [W-1:0] ref_ay;
  logic signed [W-1:0] ref_bx;
  logic signed [W-1:0] ref_by;
  logic signed [W-1:0] ref_cx;
  logic signed [W-1:0] ref_cy;

  modport source (
    output valid, def_ax, def_ay, def_bx, def_by, def_cx, def_cy,
    output ref_ax, ref_ay, ref_bx, ref_by, ref_cx, ref_cy,
    input ready
  );
  modport sink (
    input valid, def_ax, def_ay, def_bx, def_by, def_cx, def_cy,
    input ref_ax, ref_ay, ref_bx, ref_by, ref_cx, ref_cy,
    output ready
  );
endinterface

interface tsde_out_if;
  import tsde_pkg::*;
  logic valid;
  logic ready;
  logic signed [ENERGY_W-1:0] energy;
  logic inverted;
  logic saturated;

  modport source (output valid, energy, inverted, saturated, input ready);
  modport sink (input valid, energy, inverted, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/triangle_symmetric_dirichlet_energy.sv =====
`default_nettype none
// Symmetric Dirichlet energy of one triangle per item: area * (|B R^-1|^2 + |R B^-1|^2 - 4)
// from Q16.16 deformed and reference vertices, result Q32.32, saturated and flagged;
// inverted or degenerate triangles give the maximum energy with inverted set.
// Fully pipelined: one triangle accepted every clock while the result side takes results.
// At COORD_WIDTH 32 the front forms edge differences, then the determinant and adjugate
// products; the back, behind the queue, holds two 68-stage restoring dividers and the
// 17-stage wide multiplier, which runs beside the first divider and feeds the second.
// The front keeps accepting while the queue has room when the result side stalls.
module triangle_symmetric_dirichlet_energy #(
  parameter int COORD_WIDTH = tsde_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tsde_in_if.sink    tri_in,
  tsde_out_if.source res_out
);
  import tsde_pkg::*;

  localparam int QDW = 2 + 6 * (2 * COORD_WIDTH + 3);

  logic           push;
  logic           pop;
  logic           empty;
  logic           full;
  logic [QDW-1:0] push_data;
  logic [QDW-1:0] pop_data;

  tsde_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .tri_in(tri_in), .full(full), .push(push), .push_data(push_data)
  );

  tsde_fifo #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .empty(empty), .full(full)
  );

  tsde_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .pop_data(pop_data), .pop(pop), .res_out(res_out)
  );
endmodule
`default_nettype wire

// ===== sv/tsde_delay.sv =====
`default_nettype none
module tsde_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] pipe [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < DEPTH; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[DEPTH-1];
endmodule
`default_nettype wire

// ===== sv/tsde_mul.sv =====
`default_nettype none
module tsde_mul #(
  parameter int WA = tsde_pkg::COORD_WIDTH_DEF,
  parameter int WB = tsde_pkg::COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);
  import tsde_pkg::*;

  localparam int C   = MUL_CHUNK;
  localparam int NA  = (WA + C - 1) / C;
  localparam int NB  = (WB + C - 1) / C;
  localparam int NCH = NA * NB;
  localparam int PW  = NA * C + NB * C;
  localparam int RW  = WA + WB;

  logic [WA-1:0]   a_mag;
  logic [WB-1:0]   b_mag;
  logic [NA*C-1:0] am  [NCH+1];
  logic [NB*C-1:0] bm  [NCH+1];
  logic [RW-1:0]   acc [NCH+1];
  logic            sg  [NCH+1];

  assign a_mag = a[WA-1] ? ~a + 1'b1 : a;
  assign b_mag = b[WB-1] ? ~b + 1'b1 : b;

  always_ff @(posedge clk) begin
    if (en) begin
      am[0]  <= (NA*C)'(a_mag);
      bm[0]  <= (NB*C)'(b_mag);
      acc[0] <= '0;
      sg[0]  <= a[WA-1] ^ b[WB-1];
    end
  end

  // one chunk-by-chunk partial product per stage
  for (genvar k = 1; k <= NCH; k++) begin : g_pp
    localparam int I = (k - 1) / NB;
    localparam int J = (k - 1) % NB;
    logic [2*C-1:0] prod;
    logic [PW-1:0]  pp;

    assign prod = am[k-1][I*C +: C] * bm[k-1][J*C +: C];
    assign pp   = PW'(prod) << (C * (I + J));

    always_ff @(posedge clk) begin
      if (en) begin
        am[k]  <= am[k-1];
        bm[k]  <= bm[k-1];
        acc[k] <= acc[k-1] + pp[RW-1:0];
        sg[k]  <= sg[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= sg[NCH] ? ~acc[NCH] + 1'b1 : acc[NCH];
  end
endmodule
`default_nettype wire

// ===== sv/tsde_div.sv =====
`default_nettype none
module tsde_div #(
  parameter int NW  = 2 * tsde_pkg::COORD_WIDTH_DEF,
  parameter int DVW = tsde_pkg::COORD_WIDTH_DEF,
  parameter int QW  = tsde_pkg::COORD_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  n,
  input  logic [DVW-1:0] d,
  output logic [QW-1:0]  q,
  output logic           ovf
);
  localparam int HW = NW - QW;
  localparam int XW = (HW > DVW) ? HW : DVW;

  logic [XW-1:0]  hi_x;
  logic [XW-1:0]  d_x;
  logic [DVW-1:0] rem [QW+1];
  logic [QW-1:0]  low [QW+1];
  logic [QW-1:0]  quo [QW+1];
  logic [DVW-1:0] dv  [QW+1];
  logic           of  [QW+1];

  assign hi_x = XW'(n[NW-1:QW]);
  assign d_x  = XW'(d);

  always_ff @(posedge clk) begin
    if (en) begin
      of[0]  <= hi_x >= d_x;
      rem[0] <= hi_x[DVW-1:0];
      low[0] <= n[QW-1:0];
      quo[0] <= '0;
      dv[0]  <= d;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DVW:0] cand;
    logic [DVW:0] diff;
    logic         ge;

    assign cand = {rem[k-1], low[k-1][QW-1]};
    assign diff = cand - {1'b0, dv[k-1]};
    assign ge   = cand >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DVW-1:0] : cand[DVW-1:0];
        low[k] <= low[k-1] << 1;
        quo[k] <= {quo[k-1][QW-2:0], ge};
        dv[k]  <= dv[k-1];
        of[k]  <= of[k-1];
      end
    end
  end

  assign q   = quo[QW];
  assign ovf = of[QW];
endmodule
`default_nettype wire

// ===== sv/tsde_fifo.sv =====
`default_nettype none
module tsde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tsde_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    rd_next;
  logic [CW-1:0]    count;

  assign rd_next = !pop ? rd_ptr : (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // head item held in a register; an item written into an empty queue goes straight to it
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
    if (push && (wr_ptr == rd_next)) begin
      pop_data <= push_data;
    end else begin
      pop_data <= slot[rd_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      rd_ptr <= rd_next;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign empty    = count == '0;
  assign full     = count == CW'(DEPTH);
endmodule
`default_nettype wire

// ===== sv/tsde_front.sv =====
`default_nettype none
module tsde_front #(
  parameter int COORD_WIDTH = tsde_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  tsde_in_if.sink                             tri_in,
  input  logic                                full,
  output logic                                push,
  output logic [2+6*(2*COORD_WIDTH+3)-1:0]    push_data
);
  import tsde_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int DETW = 2 * DW + 1;
  localparam int LP   = mul_lat(DW, DW);

  // operand pairs: dB, dR, then the entries of B adj(R)
  localparam int PA [12] = '{0, 1, 4, 5, 0, 1, 1, 0, 2, 3, 3, 2};
  localparam int PB [12] = '{3, 2, 7, 6, 7, 6, 4, 5, 7, 6, 4, 5};

  logic                   en_f;
  logic                   v1;
  logic                   vp;
  logic                   vc;
  logic signed [DW-1:0]   dif [8];
  logic signed [2*DW-1:0] prd [12];
  logic [DETW-1:0]        dd  [6];
  logic [DETW-1:0]        db;
  logic [DETW-1:0]        ar;
  logic [DETW-1:0]        ent [4];
  tsde_flags_t            flags;
  logic [DETW-1:0]        dr;
  logic                   inv;

  assign en_f         = !(vc && full);
  assign tri_in.ready = en_f;
  assign push         = vc && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en_f) begin
      v1 <= tri_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      dif[0] <= {tri_in.def_bx[W-1], tri_in.def_bx} - {tri_in.def_ax[W-1], tri_in.def_ax};
      dif[1] <= {tri_in.def_cx[W-1], tri_in.def_cx} - {tri_in.def_ax[W-1], tri_in.def_ax};
      dif[2] <= {tri_in.def_by[W-1], tri_in.def_by} - {tri_in.def_ay[W-1], tri_in.def_ay};
      dif[3] <= {tri_in.def_cy[W-1], tri_in.def_cy} - {tri_in.def_ay[W-1], tri_in.def_ay};
      dif[4] <= {tri_in.ref_bx[W-1], tri_in.ref_bx} - {tri_in.ref_ax[W-1], tri_in.ref_ax};
      dif[5] <= {tri_in.ref_cx[W-1], tri_in.ref_cx} - {tri_in.ref_ax[W-1], tri_in.ref_ax};
      dif[6] <= {tri_in.ref_by[W-1], tri_in.ref_by} - {tri_in.ref_ay[W-1], tri_in.ref_ay};
      dif[7] <= {tri_in.ref_cy[W-1], tri_in.ref_cy} - {tri_in.ref_ay[W-1], tri_in.ref_ay};
    end
  end

  for (genvar g = 0; g < 12; g++) begin : g_mul
    tsde_mul #(.WA(DW), .WB(DW)) u_mul (
      .clk(clk), .en(en_f), .a(dif[PA[g]]), .b(dif[PB[g]]), .p(prd[g])
    );
  end

  tsde_delay #(.WIDTH(1), .DEPTH(LP)) u_vdly (
    .clk(clk), .rst(rst), .en(en_f), .d(v1), .q(vp)
  );

  for (genvar k = 0; k < 6; k++) begin : g_sub
    assign dd[k] = {prd[2*k][2*DW-1], prd[2*k]} - {prd[2*k+1][2*DW-1], prd[2*k+1]};
  end

  assign dr  = dd[1];
  assign inv = (dd[0] == '0) || (dr == '0) || (dd[0][DETW-1] != dr[DETW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en_f) begin
      vc <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      flags.inv <= inv;
      flags.neg <= dr[DETW-1];
      db        <= dd[0];
      ar        <= dr[DETW-1] ? ~dr + 1'b1 : dr;
      for (int i = 0; i < 4; i++) ent[i] <= dd[i+2];
    end
  end

  assign push_data = {flags, db, ar, ent[0], ent[1], ent[2], ent[3]};
endmodule
`default_nettype wire

// ===== sv/tsde_back.sv =====
`default_nettype none
module tsde_back #(
  parameter int COORD_WIDTH = tsde_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             empty,
  input  logic [2+6*(2*COORD_WIDTH+3)-1:0] pop_data,
  output logic                             pop,
  tsde_out_if.source                       res_out
);
  import tsde_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int DETW = 2 * DW + 1;
  localparam int MW   = 2 * DETW + 2;
  localparam int QW   = quot_w(DW);
  localparam int LS   = mul_lat(DETW, DETW);
  localparam int LM   = mul_lat(DETW + 1, MW + 1);
  localparam int LD   = QW + 1;
  localparam int NW2  = DETW + MW + 2;
  localparam int SW   = 3 + DETW;

  logic                     en_b;
  logic                     v_out;
  tsde_flags_t              q_flags;
  logic signed [DETW-1:0]   q_db;
  logic [DETW-1:0]          q_ar;
  logic signed [DETW-1:0]   q_ent [4];
  logic signed [2*DETW-1:0] sq    [5];
  logic [SW-1:0]            side_s;
  logic                     vm;
  tsde_flags_t              flags_m;
  logic [DETW-1:0]          ar_m;
  logic [MW-1:0]            msum;
  logic [2*DETW-1:0]        den;
  logic [QW-1:0]            q1;
  logic                     ovf1;
  logic [QW:0]              q1_d;
  logic signed [NW2-1:0]    prod2;
  logic [2*DETW-1:0]        den_d;
  logic [QW-1:0]            q2;
  logic                     ovf2;
  logic [SW-1:0]            side_f;
  logic                     vf;
  tsde_flags_t              flags_f;
  logic [DETW-1:0]          ar_f;
  logic [QW+1:0]            mag;
  logic [ENERGY_W-1:0]      low;
  logic                     big;
  logic [ENERGY_W-1:0]      e_next;
  logic                     sat_next;

  assign en_b = !v_out || res_out.ready;
  assign pop  = en_b && !empty;

  assign {q_flags, q_db, q_ar, q_ent[0], q_ent[1], q_ent[2], q_ent[3]} = pop_data;

  for (genvar k = 0; k < 4; k++) begin : g_sq
    tsde_mul #(.WA(DETW), .WB(DETW)) u_sq (
      .clk(clk), .en(en_b), .a(q_ent[k]), .b(q_ent[k]), .p(sq[k])
    );
  end

  tsde_mul #(.WA(DETW), .WB(DETW)) u_sqb (
    .clk(clk), .en(en_b), .a(q_db), .b(q_db), .p(sq[4])
  );

  tsde_delay #(.WIDTH(SW), .DEPTH(LS)) u_sdly (
    .clk(clk), .rst(rst), .en(en_b), .d({pop, q_flags, q_ar}), .q(side_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en_b) begin
      vm <= side_s[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      flags_m <= side_s[DETW +: 2];
      ar_m    <= side_s[DETW-1:0];
      msum    <= MW'(sq[0]) + MW'(sq[1]) + MW'(sq[2]) + MW'(sq[3]);
      den     <= {sq[4][2*DETW-2:0], 1'b0};
    end
  end

  // m / (2|dR|)
  tsde_div #(.NW(MW), .DVW(DETW), .QW(QW)) u_div1 (
    .clk(clk), .en(en_b), .n(msum), .d({ar_m[DETW-2:0], 1'b0}), .q(q1), .ovf(ovf1)
  );

  tsde_delay #(.WIDTH(QW + 1), .DEPTH(LM)) u_q1dly (
    .clk(clk), .rst(rst), .en(en_b), .d({ovf1, q1}), .q(q1_d)
  );

  // |dR| m / (2 dB^2)
  tsde_mul #(.WA(DETW + 1), .WB(MW + 1)) u_mul2 (
    .clk(clk), .en(en_b), .a({1'b0, ar_m}), .b({1'b0, msum}), .p(prod2)
  );

  tsde_delay #(.WIDTH(2 * DETW), .DEPTH(LM)) u_ddly (
    .clk(clk), .rst(rst), .en(en_b), .d(den), .q(den_d)
  );

  tsde_div #(.NW(NW2), .DVW(2 * DETW), .QW(QW)) u_div2 (
    .clk(clk), .en(en_b), .n(prod2), .d(den_d), .q(q2), .ovf(ovf2)
  );

  tsde_delay #(.WIDTH(SW), .DEPTH(LM + LD)) u_fdly (
    .clk(clk), .rst(rst), .en(en_b), .d({vm, flags_m, ar_m}), .q(side_f)
  );

  assign vf      = side_f[SW-1];
  assign flags_f = side_f[DETW +: 2];
  assign ar_f    = side_f[DETW-1:0];

  always_comb begin
    mag = (QW+2)'(q1_d[QW-1:0]) + (QW+2)'(q2) - (QW+2)'({ar_f[DETW-2:0], 1'b0});
    low = mag[QW+1] ? '0 : mag[ENERGY_W-1:0];
    big = q1_d[QW] || ovf2 || (!mag[QW+1] && (mag[QW:ENERGY_W] != '0));
    if (flags_f.inv) begin
      e_next   = ENERGY_MAX;
      sat_next = 1'b0;
    end else if (!flags_f.neg) begin
      if (big || low[ENERGY_W-1]) begin
        e_next   = ENERGY_MAX;
        sat_next = 1'b1;
      end else begin
        e_next   = low;
        sat_next = 1'b0;
      end
    end else begin
      if (big || (low > ENERGY_MIN)) begin
        e_next   = ENERGY_MIN;
        sat_next = 1'b1;
      end else begin
        e_next   = ~low + 1'b1;
        sat_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en_b) begin
      v_out <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      res_out.energy    <= e_next;
      res_out.inverted  <= flags_f.inv;
      res_out.saturated <= sat_next;
    end
  end

  assign res_out.valid = v_out;
endmodule
`default_nettype wire

// ===== dv/tsde_energy_checker.sv =====
module tsde_energy_checker (
  input  logic clk,
  input  logic rst,
  tsde_in_if   tri_in,
  tsde_out_if  res_out,
  output int   errors,
  output int   pending
);
  import tsde_pkg::*;

  typedef logic signed [383:0] wide_t;

  typedef struct {
    logic [ENERGY_W-1:0] energy;
    logic                inverted;
    logic                saturated;
  } energy_res_t;

  energy_res_t energy_q[$];

  function automatic energy_res_t triangle_energy(input logic signed [31:0] c[12]);
    wide_t       v[12];
    wide_t       b00, b01, b10, b11, r00, r01, r10, r11, db, dr, ar, m1, m2, mag;
    wide_t       lim;
    logic        neg;
    energy_res_t r;
    for (int i = 0; i < 12; i++) v[i] = wide_t'(c[i]);
    b00 = v[2] - v[0];   b01 = v[4] - v[0];
    b10 = v[3] - v[1];   b11 = v[5] - v[1];
    r00 = v[8] - v[6];   r01 = v[10] - v[6];
    r10 = v[9] - v[7];   r11 = v[11] - v[7];
    db = b00 * b11 - b01 * b10;
    dr = r00 * r11 - r01 * r10;
    r.inverted = 1'b0;
    r.saturated = 1'b0;
    if (db == 0 || dr == 0 || (db < 0) != (dr < 0)) begin
      r.energy = ENERGY_MAX;
      r.inverted = 1'b1;
      return r;
    end
    neg = dr < 0;
    ar = neg ? -dr : dr;
    m1 = (b00 * r11 - b01 * r10) ** 2 + (b01 * r00 - b00 * r01) ** 2
       + (b10 * r11 - b11 * r10) ** 2 + (b11 * r00 - b10 * r01) ** 2;
    m2 = (r00 * b11 - r01 * b10) ** 2 + (r01 * b00 - r00 * b01) ** 2
       + (r10 * b11 - r11 * b10) ** 2 + (r11 * b00 - r10 * b01) ** 2;
    mag = m1 / (2 * ar) + (ar * m2) / (2 * db * db) - 2 * ar;
    if (mag < 0) mag = 0;
    lim = neg ? (wide_t'(1) <<< 63) : (wide_t'(1) <<< 63) - 1;
    if (mag > lim) begin
      r.saturated = 1'b1;
      r.energy = neg ? ENERGY_MIN : ENERGY_MAX;
    end else begin
      r.energy = neg ? -mag[63:0] : mag[63:0];
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = energy_q.size();

  always @(posedge clk) begin
    logic signed [31:0] c[12];
    energy_res_t        exp_r;
    if (rst) errors = 0;
    if (!rst && tri_in.valid && tri_in.ready) begin
      c = '{tri_in.def_ax, tri_in.def_ay, tri_in.def_bx, tri_in.def_by,
            tri_in.def_cx, tri_in.def_cy, tri_in.ref_ax, tri_in.ref_ay,
            tri_in.ref_bx, tri_in.ref_by, tri_in.ref_cx, tri_in.ref_cy};
      energy_q = {energy_q, triangle_energy(c)};
    end
    if (!rst && res_out.valid && res_out.ready) begin
      if (energy_q.size() == 0) begin
        report("unexpected item", res_out.energy, '0);
      end else begin
        exp_r = energy_q.pop_front();
        if (res_out.energy !== exp_r.energy)
          report("energy", res_out.energy, exp_r.energy);
        if (res_out.inverted !== exp_r.inverted)
          report("inverted", 64'(res_out.inverted), 64'(exp_r.inverted));
        if (res_out.saturated !== exp_r.saturated)
          report("saturated", 64'(res_out.saturated), 64'(exp_r.saturated));
      end
    end
  end

endmodule

// ===== dv/triangle_symmetric_dirichlet_energy_tb.sv =====
module triangle_symmetric_dirichlet_energy_tb;

  localparam int N_RANDOM = 1930;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  int   errors;
  int   pending;
  int   cycles = 0;

  tsde_in_if  tri_in ();
  tsde_out_if res_out ();

  triangle_symmetric_dirichlet_energy u_top (
    .clk     (clk),
    .rst     (rst),
    .tri_in  (tri_in.sink),
    .res_out (res_out.source)
  );

  tsde_energy_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .tri_in  (tri_in),
    .res_out (res_out),
    .errors  (errors),
    .pending (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    res_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 2) != 0) begin
        res_out.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        res_out.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [31:0] rnd_coord(input int span);
    return $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
  endfunction

  task automatic send(input logic signed [31:0] c[12]);
    logic rdy;
    tri_in.valid  <= 1'b1;
    tri_in.def_ax <= c[0];  tri_in.def_ay <= c[1];
    tri_in.def_bx <= c[2];  tri_in.def_by <= c[3];
    tri_in.def_cx <= c[4];  tri_in.def_cy <= c[5];
    tri_in.ref_ax <= c[6];  tri_in.ref_ay <= c[7];
    tri_in.ref_bx <= c[8];  tri_in.ref_by <= c[9];
    tri_in.ref_cx <= c[10]; tri_in.ref_cy <= c[11];
    do begin
      @(negedge clk);
      rdy = tri_in.ready;
      @(posedge clk);
    end while (!rdy);
    if (!calm && $urandom_range(0, 3) == 0) begin
      tri_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // well-formed triangle: deformed is a perturbed copy of the reference
  task automatic shaped_item(output logic signed [31:0] c[12]);
    int span, nsp;
    span = $urandom_range(14, 24);
    nsp = $urandom_range(4, span);
    for (int i = 6; i < 12; i++) c[i] = rnd_coord(span);
    for (int i = 0; i < 6; i++) c[i] = c[i + 6] + rnd_coord(nsp);
    if ($urandom_range(0, 3) == 0) begin
      // mirror both, negative area
      c[1] = -c[1]; c[3] = -c[3]; c[5] = -c[5];
      c[7] = -c[7]; c[9] = -c[9]; c[11] = -c[11];
    end
  endtask

  initial begin
    logic signed [31:0] c[12];
    logic signed [31:0] u;
    tri_in.valid = 1'b0;
    {tri_in.def_ax, tri_in.def_ay, tri_in.def_bx, tri_in.def_by,
     tri_in.def_cx, tri_in.def_cy} = '0;
    {tri_in.ref_ax, tri_in.ref_ay, tri_in.ref_bx, tri_in.ref_by,
     tri_in.ref_cx, tri_in.ref_cy} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    u = 32'sh0001_0000;
    // identity, zero energy
    c = '{0, 0, u, 0, 0, u, 0, 0, u, 0, 0, u};
    send(c);
    // uniform scale
    c = '{0, 0, 2*u, 0, 0, 2*u, 0, 0, u, 0, 0, u};
    send(c);
    // shear
    c = '{0, 0, u, 0, u, u, 0, 0, u, 0, 0, u};
    send(c);
    // negative area, same orientation
    c = '{0, 0, u, 0, 0, -u, 0, 0, u, 0, 0, -u};
    send(c);
    c = '{0, 0, 3*u, 0, 0, -u, 0, 0, u, 0, 0, -u};
    send(c);
    // inverted
    c = '{0, 0, u, 0, 0, -u, 0, 0, u, 0, 0, u};
    send(c);
    // degenerate deformed, degenerate reference, all zero
    c = '{0, 0, u, u, 2*u, 2*u, 0, 0, u, 0, 0, u};
    send(c);
    c = '{0, 0, u, 0, 0, u, 5, 5, 5, 5, 5, 5};
    send(c);
    c = '{default: 0};
    send(c);
    // extremes of the coordinate range
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 1, 0, 0, 1};
    send(c);
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 1, 0, 0, -1};
    send(c);
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh8000_0000, 32'sh7fff_ffff, 0, 0, -1, 0, 0, -1};
    send(c);
    c = '{0, 0, 1, 0, 0, 1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff};
    send(c);
    c = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
          32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000};
    send(c);
    // tiny triangles, rounding near zero
    c = '{0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1};
    send(c);
    c = '{0, 0, 2, 0, 0, 1, 0, 0, 1, 0, 0, 2};
    send(c);
    c = '{0, 0, 2, 0, 1, 1, 0, 0, -1, 0, 0, -2};
    send(c);
    c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
    send(c);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 200) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        shaped_item(c);
      end else begin
        for (int i = 0; i < 12; i++) c[i] = $urandom();
      end
      send(c);
    end
    tri_in.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
